[design/aesme_pkg.sv]
package aesme_pkg;

  typedef enum logic [1:0] {
    MODE_ECB  = 2'd0,
    MODE_CBC  = 2'd1,
    MODE_CFB8 = 2'd2,
    MODE_OFB8 = 2'd3
  } mode_t;

  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_KEY_HIGH    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_KEY_LOW     = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_IV_HIGH     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_IV_LOW      = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_CIPHER_MODE = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_DECRYPT_SEL = 3'd5;

  localparam logic [3:0] LAST_ROUND = 4'd10;
  localparam logic [3:0] LAST_BYTE  = 4'd15;

  typedef struct packed {
    logic [127:0] key;
    logic [127:0] iv;
  } cfg_t;

  typedef struct packed {
    logic [127:0] blk;
    logic         first;
    mode_t        mode;
    logic         dec;
  } entry_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_START,
    B_KEYX,
    B_ENC,
    B_DEC,
    B_FIN,
    B_OUT
  } bstate_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [2047:0] build_inv();
    logic [2047:0] t;
    t = '0;
    for (int i = 0; i < 256; i++) begin
      t[SBOX[i]*8 +: 8] = 8'(i);
    end
    return t;
  endfunction

  localparam logic [2047:0] INV_SBOX = build_inv();

  function automatic logic [7:0] inv_sbox(input logic [7:0] a);
    return INV_SBOX[{a, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] rnd);
    logic [7:0] r;
    unique case (rnd)
      4'd1:    r = 8'h01;
      4'd2:    r = 8'h02;
      4'd3:    r = 8'h04;
      4'd4:    r = 8'h08;
      4'd5:    r = 8'h10;
      4'd6:    r = 8'h20;
      4'd7:    r = 8'h40;
      4'd8:    r = 8'h80;
      4'd9:    r = 8'h1b;
      4'd10:   r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // byte k of a 128-bit value, byte 0 most significant
  function automatic logic [7:0] byte_of(input logic [127:0] v, input int k);
    return v[127-8*k -: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_rot(input logic [31:0] w, input logic [7:0] rc);
    return {SBOX[w[23:16]] ^ rc, SBOX[w[15:8]], SBOX[w[7:0]], SBOX[w[31:24]]};
  endfunction

  function automatic logic [127:0] key_fwd(input logic [127:0] k, input logic [3:0] rnd);
    logic [31:0] n0, n1, n2, n3;
    n0 = k[127:96] ^ sub_rot(k[31:0], rcon(rnd));
    n1 = k[95:64] ^ n0;
    n2 = k[63:32] ^ n1;
    n3 = k[31:0] ^ n2;
    return {n0, n1, n2, n3};
  endfunction

  function automatic logic [127:0] key_bwd(input logic [127:0] k, input logic [3:0] rnd);
    logic [31:0] p0, p1, p2, p3;
    p3 = k[31:0] ^ k[63:32];
    p2 = k[63:32] ^ k[95:64];
    p1 = k[95:64] ^ k[127:96];
    p0 = k[127:96] ^ sub_rot(p3, rcon(rnd));
    return {p0, p1, p2, p3};
  endfunction

  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic last);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    logic [127:0] o;
    for (int i = 0; i < 16; i++) b[i] = SBOX[byte_of(s, i)];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) t[c*4+r] = b[((c+r)%4)*4+r];
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
        al = a0 ^ a1 ^ a2 ^ a3;
        t[c*4]   = a0 ^ al ^ xtime(a0 ^ a1);
        t[c*4+1] = a1 ^ al ^ xtime(a1 ^ a2);
        t[c*4+2] = a2 ^ al ^ xtime(a2 ^ a3);
        t[c*4+3] = a3 ^ al ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) o[127-8*i -: 8] = t[i];
    return o ^ rk;
  endfunction

  function automatic logic [7:0] gm(input logic [7:0] a, input logic [3:0] m);
    logic [7:0] x1, x2, x3;
    x1 = xtime(a);
    x2 = xtime(x1);
    x3 = xtime(x2);
    return (m[0] ? a : 8'h00) ^ (m[1] ? x1 : 8'h00) ^ (m[2] ? x2 : 8'h00) ^
           (m[3] ? x3 : 8'h00);
  endfunction

  function automatic logic [127:0] dec_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic last);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    logic [127:0] v, o;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) t[((c+r)%4)*4+r] = byte_of(s, c*4+r);
    for (int i = 0; i < 16; i++) v[127-8*i -: 8] = inv_sbox(t[i]);
    v = v ^ rk;
    o = v;
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = byte_of(v, c*4); a1 = byte_of(v, c*4+1);
        a2 = byte_of(v, c*4+2); a3 = byte_of(v, c*4+3);
        o[127-8*(c*4)   -: 8] = gm(a0, 4'd14) ^ gm(a1, 4'd11) ^ gm(a2, 4'd13) ^ gm(a3, 4'd9);
        o[127-8*(c*4+1) -: 8] = gm(a0, 4'd9) ^ gm(a1, 4'd14) ^ gm(a2, 4'd11) ^ gm(a3, 4'd13);
        o[127-8*(c*4+2) -: 8] = gm(a0, 4'd13) ^ gm(a1, 4'd9) ^ gm(a2, 4'd14) ^ gm(a3, 4'd11);
        o[127-8*(c*4+3) -: 8] = gm(a0, 4'd11) ^ gm(a1, 4'd13) ^ gm(a2, 4'd9) ^ gm(a3, 4'd14);
      end
    end
    return o;
  endfunction

endpackage

[design/aesme_in_if.sv]
interface aesme_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_in_high;
  logic [63:0] block_in_low;
  logic        first_block;

  modport source (output valid, output block_in_high, output block_in_low,
                  output first_block, input ready);
  modport sink (input valid, input block_in_high, input block_in_low,
                input first_block, output ready);
endinterface

[design/aesme_out_if.sv]
interface aesme_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_out_high;
  logic [63:0] block_out_low;

  modport source (output valid, output block_out_high, output block_out_low, input ready);
  modport sink (input valid, input block_out_high, input block_out_low, output ready);
endinterface

[design/aes128_mode_engine.sv]
// AES-128 block engine, ECB / CBC / CFB-8 / OFB-8, one 128-bit block in and
// one out per item. Set key, IV, mode and direction through the write port
// while the block is idle; first_block reloads the chaining value from the IV.
// The cipher core does one round per cycle with the round key computed on the
// fly. In ECB and CBC decryption the schedule is run forward first, then
// backward. CFB-8 and OFB-8 run sixteen chained cipher passes per block. A
// two-entry queue takes items while the core works, and a finished block waits
// in the output register, so the core only stalls when the next block is done
// before the previous one has been taken.
module aes128_mode_engine
  import aesme_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  aesme_in_if.sink           in_ch,
  aesme_out_if.source        out_ch,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [63:0]        cfg_data
);

  cfg_t   cfg;
  entry_t q_entry, q_head;
  logic   q_push, q_pop, q_full, q_valid;

  aesme_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_entry),
    .cfg       (cfg)
  );

  aesme_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .full       (q_full),
    .not_empty  (q_valid),
    .head       (q_head)
  );

  aesme_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

[design/aesme_front.sv]
module aesme_front
  import aesme_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  aesme_in_if.sink           in_ch,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               q_full,
  output logic               q_push,
  output entry_t             q_entry,
  output cfg_t               cfg
);

  logic [63:0] key_high, key_low, iv_high, iv_low;
  mode_t       cipher_mode;
  logic        decrypt_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high    <= '0;
      key_low     <= '0;
      iv_high     <= '0;
      iv_low      <= '0;
      cipher_mode <= MODE_ECB;
      decrypt_sel <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_HIGH:    key_high    <= cfg_data;
        REG_KEY_LOW:     key_low     <= cfg_data;
        REG_IV_HIGH:     iv_high     <= cfg_data;
        REG_IV_LOW:      iv_low      <= cfg_data;
        REG_CIPHER_MODE: cipher_mode <= mode_t'(cfg_data[1:0]);
        REG_DECRYPT_SEL: decrypt_sel <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  // OFB runs the same keystream either way: fold decrypt away
  always_comb begin
    q_entry.blk   = {in_ch.block_in_high, in_ch.block_in_low};
    q_entry.first = in_ch.first_block;
    q_entry.mode  = cipher_mode;
    q_entry.dec   = decrypt_sel && (cipher_mode != MODE_OFB8);
  end

  assign cfg.key = {key_high, key_low};
  assign cfg.iv  = {iv_high, iv_low};

endmodule

[design/aesme_queue.sv]
module aesme_queue
  import aesme_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output logic   full,
  output logic   not_empty,
  output entry_t head
);

  entry_t     slots [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop)  rptr <= !rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

[design/aesme_back.sv]
module aesme_back
  import aesme_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     q_valid,
  input  entry_t   q_head,
  output logic     q_pop,
  aesme_out_if.source out_ch
);

  bstate_t      state, state_next;
  entry_t       item, item_next;
  logic [127:0] blk, blk_next;
  logic [127:0] chn, chn_next;
  logic [127:0] s, s_next;
  logic [127:0] rk, rk_next;
  logic [127:0] res, res_next;
  logic [3:0]   rnd, rnd_next;
  logic [3:0]   step, step_next;
  logic         ovalid, ovalid_next;
  logic [127:0] obuf, obuf_next;

  logic [127:0] rk_f, rk_b, cin;
  logic [7:0]   kbyte, rbyte, fb;
  logic         stream;

  assign rk_f   = key_fwd(rk, rnd);
  assign rk_b   = key_bwd(rk, rnd);
  assign stream = (item.mode == MODE_CFB8) || (item.mode == MODE_OFB8);
  assign kbyte  = s[127:120];
  assign rbyte  = blk[127:120] ^ kbyte;

  always_comb begin
    unique case (item.mode)
      MODE_ECB:  cin = item.blk;
      MODE_CBC:  cin = item.dec ? item.blk : (item.blk ^ chn);
      MODE_CFB8: cin = chn;
      MODE_OFB8: cin = chn;
      default:   cin = chn;
    endcase
    unique case (item.mode)
      MODE_OFB8: fb = kbyte;
      default:   fb = item.dec ? blk[127:120] : rbyte;
    endcase
  end

  always_comb begin
    state_next  = state;
    item_next   = item;
    blk_next    = blk;
    chn_next    = chn;
    s_next      = s;
    rk_next     = rk;
    res_next    = res;
    rnd_next    = rnd;
    step_next   = step;
    obuf_next   = obuf;
    ovalid_next = ovalid && !out_ch.ready;
    q_pop       = 1'b0;

    unique case (state)
      B_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          item_next  = q_head;
          blk_next   = q_head.blk;
          step_next  = 4'd0;
          if (q_head.first) chn_next = cfg.iv;
          state_next = B_START;
        end
      end
      B_START: begin
        rk_next  = cfg.key;
        rnd_next = 4'd1;
        if (item.dec && !stream) begin
          state_next = B_KEYX;
        end else begin
          s_next     = cin ^ cfg.key;
          state_next = B_ENC;
        end
      end
      B_KEYX: begin
        // run the schedule up to the last round key, then start from it
        rk_next = rk_f;
        if (rnd == LAST_ROUND) begin
          s_next     = item.blk ^ rk_f;
          rnd_next   = LAST_ROUND;
          state_next = B_DEC;
        end else begin
          rnd_next = rnd + 4'd1;
        end
      end
      B_ENC: begin
        rk_next  = rk_f;
        s_next   = enc_round(s, rk_f, rnd == LAST_ROUND);
        rnd_next = rnd + 4'd1;
        if (rnd == LAST_ROUND) state_next = B_FIN;
      end
      B_DEC: begin
        rk_next  = rk_b;
        s_next   = dec_round(s, rk_b, rnd == 4'd1);
        rnd_next = rnd - 4'd1;
        if (rnd == 4'd1) state_next = B_FIN;
      end
      B_FIN: begin
        state_next = B_OUT;
        unique case (item.mode)
          MODE_ECB: res_next = s;
          MODE_CBC: begin
            if (item.dec) begin
              res_next = s ^ chn;
              chn_next = item.blk;
            end else begin
              res_next = s;
              chn_next = s;
            end
          end
          default: begin
            res_next  = {res[119:0], rbyte};
            chn_next  = {chn[119:0], fb};
            blk_next  = {blk[119:0], 8'h00};
            step_next = step + 4'd1;
            if (step != LAST_BYTE) state_next = B_START;
          end
        endcase
      end
      B_OUT: begin
        if (!ovalid || out_ch.ready) begin
          obuf_next   = res;
          ovalid_next = 1'b1;
          state_next  = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= B_IDLE;
      ovalid <= 1'b0;
      chn    <= '0;
    end else begin
      state  <= state_next;
      ovalid <= ovalid_next;
      chn    <= chn_next;
    end
  end

  always_ff @(posedge clk) begin
    item <= item_next;
    blk  <= blk_next;
    s    <= s_next;
    rk   <= rk_next;
    res  <= res_next;
    rnd  <= rnd_next;
    step <= step_next;
    obuf <= obuf_next;
  end

  assign out_ch.valid          = ovalid;
  assign out_ch.block_out_high = obuf[127:64];
  assign out_ch.block_out_low  = obuf[63:0];

endmodule

[design/aesme_checker.sv]
module aesme_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_high,
  input logic [63:0] out_low
);

  logic [2:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 3'(in_valid && in_ready) - 3'(out_valid && out_ready);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_high) && $stable(out_low))
    else $error("stalled output changed");

  a_reset_quiet: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 3'd0)
    else $error("output with no item outstanding");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending <= 3'd4)
    else $error("more items held than storage allows");

endmodule

bind aes128_mode_engine aesme_checker u_aesme_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_high  (out_ch.block_out_high),
  .out_low   (out_ch.block_out_low)
);
